// ===== rtl/core/bole_pkg.sv =====
package bole_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 6;
	localparam int SEL_W  = 3;

	typedef logic [OP_W-1:0]          op_t;
	typedef logic [ST_W-1:0]          st_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [SEL_W-1:0]         sel_t;
	typedef logic signed [DATA_W-1:0] data_t;

	// Operation codes of a request.
	localparam op_t OP_FRONT  = 3'd0;
	localparam op_t OP_END    = 3'd1;
	localparam op_t OP_SORTED = 3'd2;
	localparam op_t OP_DELETE = 3'd3;
	localparam op_t OP_DUMP   = 3'd4;

	// Status codes of a result.
	localparam st_t ST_OK       = 2'd0;
	localparam st_t ST_FULL     = 2'd1;
	localparam st_t ST_NOTFOUND = 2'd2;
	localparam st_t ST_EMPTY    = 2'd3;

	// Source that a cell loads from in the next cycle.
	localparam sel_t SEL_KEEP = 3'd0;
	localparam sel_t SEL_PREV = 3'd1;
	localparam sel_t SEL_NEXT = 3'd2;
	localparam sel_t SEL_NEW  = 3'd3;
	localparam sel_t SEL_HEAD = 3'd4;

	// Comparison of a cell's value against the key of a request.
	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cell_cmp_t;

endpackage

// ===== rtl/core/bole_if.sv =====
interface bole_req_if;
	import bole_pkg::*;

	logic  valid;
	logic  ready;
	op_t   operation;
	data_t value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bole_rsp_if;
	import bole_pkg::*;

	logic  valid;
	logic  ready;
	st_t   status;
	data_t element;
	len_t  length;
	logic  last;

	modport source (output valid, output status, output element, output length,
		output last, input ready);
	modport sink   (input valid, input status, input element, input length,
		input last, output ready);
endinterface

// ===== rtl/core/bole_cell.sv =====
module bole_cell
	import bole_pkg::*;
(
	input  logic      clk,
	input  sel_t      sel,
	input  data_t     prev_val,
	input  data_t     next_val,
	input  data_t     head_val,
	input  data_t     ins_val,
	input  data_t     key,
	output data_t     val,
	output cell_cmp_t cmp
);

	data_t val_q;

	always_ff @(posedge clk) begin
		unique case (sel)
			SEL_KEEP: val_q <= val_q;
			SEL_PREV: val_q <= prev_val;
			SEL_NEXT: val_q <= next_val;
			SEL_NEW:  val_q <= ins_val;
			SEL_HEAD: val_q <= head_val;
			default:  val_q <= val_q;
		endcase
	end

	assign val    = val_q;
	assign cmp.lt = val_q < key;
	assign cmp.eq = val_q == key;
	assign cmp.gt = val_q > key;

endmodule

// ===== rtl/core/bounded_ordered_list_engine_unit.sv =====
// Insert, delete and unrecognized requests: the cells compare against the value in the
// cycle the request is accepted and the hit flags are registered; the list shifts and the
// result is registered once the output register is free. No new request is accepted until then.
// A dump emits one result per element (one for an empty list), each once the output is free.
// A stalled result holds the evaluation of the following request until the output register frees.
// Reset clears the count, the control state and the result valid flag, not the cells.
module bounded_ordered_list_engine_unit
	import bole_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bole_req_if.sink   req,
	bole_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] occ_q;
	logic [IW-1:0] cnt_q;
	op_t           op_q;
	data_t         value_q;
	logic [DEPTH-1:0] ins_hit_q;
	logic [DEPTH-1:0] del_hit_q;

	logic  rsp_valid_q;
	st_t   status_q;
	data_t element_q;
	len_t  length_q;
	logic  last_q;

	data_t     cell_val [DEPTH];
	cell_cmp_t cmp      [DEPTH];
	sel_t      sel      [DEPTH];

	logic [DEPTH-1:0] valid, ins_hit_d, del_hit_d, ins_pre, del_pre, after, first;

	logic req_fire, out_free, is_ins, full, found, dump_last, emit;
	logic [CW-1:0] occ_next;
	st_t   status_d;
	data_t element_d;
	logic  last_d;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			data_t prev_v, next_v;
			if (g == 0) begin : g_first
				assign prev_v = value_q;
			end else begin : g_mid_prev
				assign prev_v = cell_val[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign next_v = value_q;
			end else begin : g_mid_next
				assign next_v = cell_val[g+1];
			end
			bole_cell u_cell (
				.clk      (clk),
				.sel      (sel[g]),
				.prev_val (prev_v),
				.next_val (next_v),
				.head_val (cell_val[0]),
				.ins_val  (value_q),
				.key      (req.value),
				.val      (cell_val[g]),
				.cmp      (cmp[g])
			);
		end
	endgenerate

	// Per-cell hit flags, taken from the key presented with the request.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid[i]     = CW'(i) < occ_q;
			ins_hit_d[i] = valid[i] && ((i == 0) ? cmp[i].gt : !cmp[i].lt);
			del_hit_d[i] = valid[i] && cmp[i].eq;
		end
	end

	// Inclusive prefix OR marks every cell at or after the first hit.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ins_pre[i] = |(ins_hit_q & ~({DEPTH{1'b1}} << (i + 1)));
			del_pre[i] = |(del_hit_q & ~({DEPTH{1'b1}} << (i + 1)));
		end
	end

	always_comb begin
		if (op_q == OP_FRONT) begin
			after = {DEPTH{1'b1}};
		end else if (op_q == OP_END) begin
			after = ~valid;
		end else begin
			after = ins_pre | ~valid;
		end
		first = after & ~{after[DEPTH-2:0], 1'b0};
	end

	assign is_ins    = (op_q == OP_FRONT) || (op_q == OP_END) || (op_q == OP_SORTED);
	assign full      = (occ_q == CW'(DEPTH));
	assign found     = |del_hit_q;
	assign dump_last = (CW'(cnt_q) == occ_q - CW'(1)) || (occ_q == '0);
	assign emit      = out_free && ((state_q == S_EVAL) || (state_q == S_DUMP));

	always_comb begin
		occ_next  = occ_q;
		status_d  = ST_OK;
		element_d = '0;
		last_d    = 1'b1;
		if (state_q == S_DUMP) begin
			if (occ_q == '0) begin
				status_d = ST_EMPTY;
			end else begin
				element_d = cell_val[0];
				last_d    = dump_last;
			end
		end else if (is_ins) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				occ_next = occ_q + CW'(1);
			end
		end else if (op_q == OP_DELETE) begin
			if (found) begin
				occ_next = occ_q - CW'(1);
			end else begin
				status_d = ST_NOTFOUND;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			sel[i] = SEL_KEEP;
			if (emit && state_q == S_EVAL) begin
				if (is_ins && !full && after[i]) begin
					sel[i] = first[i] ? SEL_NEW : SEL_PREV;
				end else if (op_q == OP_DELETE && found && del_pre[i]) begin
					sel[i] = SEL_NEXT;
				end
			end else if (emit && state_q == S_DUMP) begin
				// Rotate the occupied part so the next element reaches the head.
				if (CW'(i + 1) < occ_q) begin
					sel[i] = SEL_NEXT;
				end else if (CW'(i + 1) == occ_q) begin
					sel[i] = SEL_HEAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						cnt_q   <= '0;
						state_q <= (req.operation == OP_DUMP) ? S_DUMP : S_EVAL;
					end
				end
				S_EVAL: begin
					if (emit) begin
						occ_q   <= occ_next;
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (emit) begin
						cnt_q <= cnt_q + IW'(1);
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q      <= req.operation;
			value_q   <= req.value;
			ins_hit_q <= ins_hit_d;
			del_hit_q <= del_hit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= status_d;
			element_q <= element_d;
			length_q  <= LEN_W'(occ_next);
			last_q    <= last_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = status_q;
	assign rsp.element = element_q;
	assign rsp.length  = length_q;
	assign rsp.last    = last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("element count exceeds depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && emit && is_ins && !full) |=> occ_q == $past(occ_q) + CW'(1))
		else $error("insert did not grow the list");

	a_dump_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> occ_q == $past(occ_q))
		else $error("element count changed during dump");

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP && emit && dump_last) |=> state_q == S_IDLE)
		else $error("dump did not end after its last element");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == ST_FULL) |-> occ_q == CW'(DEPTH))
		else $error("full status reported on a list that is not full");

endmodule

// ===== dv/tb_bounded_ordered_list_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine_unit;
	import bole_pkg::*;

	localparam int DEPTH        = 32;
	localparam int RANDOM_ITEMS = 387;
	localparam int TAIL_ITEMS   = 60;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
	localparam int MAX_REPORTS  = 10;
	localparam int DIR_ROWS     = 23;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	// Codes outside the operation set; the block answers them with an OK status and leaves the list as is.
	localparam op_t OP_SPARE_5 = 3'd5;
	localparam op_t OP_SPARE_6 = 3'd6;
	localparam op_t OP_SPARE_7 = 3'd7;

	localparam data_t VAL_MIN = 32'sh8000_0000;
	localparam data_t VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		st_t   status;
		data_t element;
		len_t  length;
		logic  last;
	} list_result_t;

	typedef struct packed {
		op_t   op;
		data_t value;
		logic  typed;
		st_t   status;
		len_t  length;
	} directed_row_t;

	typedef enum int {PH_GROW, PH_SHRINK, PH_SORTED, PH_MIX} phase_t;

	logic clk = 1'b0;
	logic arst_n;

	bole_req_if req_bus ();
	bole_rsp_if rsp_bus ();

	bounded_ordered_list_engine_unit #(
		.DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus.sink),
		.rsp   (rsp_bus.source)
	);

	data_t        list_q[$];
	list_result_t expected_q[$];
	int           mismatch_count = 0;
	int           counted = 0;
	bit           quiet_tail = 1'b0;
	int           ready_hold = 0;

	always #5 clk = ~clk;

	function automatic void push_result(input st_t status, input data_t element,
		input logic last);
		list_result_t r;
		r.status  = status;
		r.element = element;
		r.length  = len_t'(list_q.size());
		r.last    = last;
		expected_q.push_back(r);
	endfunction

	// Applies one request to the list and queues the results it produces.
	function automatic void apply_to_list(input op_t op, input data_t v);
		st_t st;
		int  pos;
		st = ST_OK;
		if (op == OP_DUMP) begin
			if (list_q.size() == 0) begin
				push_result(ST_EMPTY, '0, 1'b1);
			end else begin
				foreach (list_q[i])
					push_result(ST_OK, list_q[i], i == list_q.size() - 1);
			end
			return;
		end
		case (op) inside
			OP_FRONT, OP_END, OP_SORTED: begin
				if (list_q.size() >= DEPTH) begin
					st = ST_FULL;
				end else begin
					if (op == OP_FRONT) begin
						pos = 0;
					end else if (op == OP_END) begin
						pos = list_q.size();
					end else if (list_q.size() == 0 || v < list_q[0]) begin
						pos = 0;
					end else begin
						pos = 1;
						while (pos < list_q.size() && list_q[pos] < v)
							pos++;
					end
					list_q.insert(pos, v);
				end
			end
			OP_DELETE: begin
				pos = 0;
				while (pos < list_q.size() && list_q[pos] != v)
					pos++;
				if (pos >= list_q.size())
					st = ST_NOTFOUND;
				else
					list_q.delete(pos);
			end
			default: ;
		endcase
		push_result(st, '0, 1'b1);
	endfunction

	function automatic directed_row_t directed_row(input int k);
		case (k)
			0:  return '{OP_DUMP,    32'sd0,        1'b1, ST_EMPTY,    6'd0};
			1:  return '{OP_DELETE,  32'sd0,        1'b1, ST_NOTFOUND, 6'd0};
			2:  return '{OP_SPARE_5, -32'sd1,       1'b1, ST_OK,       6'd0};
			3:  return '{OP_SORTED,  VAL_MAX,       1'b1, ST_OK,       6'd1};
			4:  return '{OP_SORTED,  VAL_MIN,       1'b1, ST_OK,       6'd2};
			5:  return '{OP_FRONT,   -32'sd1,       1'b1, ST_OK,       6'd3};
			6:  return '{OP_END,     32'sd0,        1'b1, ST_OK,       6'd4};
			7:  return '{OP_SORTED,  32'sd5,        1'b0, ST_OK,       6'd0};
			8:  return '{OP_SORTED,  -32'sd1,       1'b0, ST_OK,       6'd0};
			9:  return '{OP_SORTED,  VAL_MIN,       1'b0, ST_OK,       6'd0};
			10: return '{OP_SORTED,  VAL_MAX,       1'b0, ST_OK,       6'd0};
			11: return '{OP_DUMP,    32'sd0,        1'b0, ST_OK,       6'd0};
			12: return '{OP_DELETE,  VAL_MIN,       1'b1, ST_OK,       6'd7};
			13: return '{OP_DELETE,  32'sd12345,    1'b1, ST_NOTFOUND, 6'd7};
			14: return '{OP_DELETE,  VAL_MAX,       1'b1, ST_OK,       6'd6};
			15: return '{OP_SPARE_6, VAL_MAX,       1'b1, ST_OK,       6'd6};
			16: return '{OP_SPARE_7, VAL_MIN,       1'b1, ST_OK,       6'd6};
			17: return '{OP_END,     32'sh5555_5555, 1'b1, ST_OK,      6'd7};
			18: return '{OP_FRONT,   32'shAAAA_AAAA, 1'b1, ST_OK,      6'd8};
			19: return '{OP_SORTED,  32'sd0,        1'b0, ST_OK,       6'd0};
			20: return '{OP_DUMP,    VAL_MAX,       1'b0, ST_OK,       6'd0};
			21: return '{OP_DELETE,  32'sd0,        1'b0, ST_OK,       6'd0};
			default: return '{OP_DUMP, VAL_MIN,     1'b0, ST_OK,       6'd0};
		endcase
	endfunction

	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			1, 2, 3, 4: return data_t'($urandom_range(0, 15)) - 32'sd8;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic data_t pick_delete_value();
		if (list_q.size() != 0 && $urandom_range(0, 3) != 0)
			return list_q[$urandom_range(0, list_q.size() - 1)];
		return pick_value();
	endfunction

	function automatic op_t pick_operation(input phase_t phase);
		int r;
		r = $urandom_range(0, 99);
		case (phase)
			PH_GROW: begin
				if (r < 28) return OP_FRONT;
				if (r < 55) return OP_END;
				if (r < 80) return OP_SORTED;
				if (r < 90) return OP_DELETE;
				if (r < 97) return OP_DUMP;
			end
			PH_SHRINK: begin
				if (r < 15) return op_t'($urandom_range(OP_FRONT, OP_SORTED));
				if (r < 80) return OP_DELETE;
				if (r < 95) return OP_DUMP;
			end
			PH_SORTED: begin
				if (r < 70) return OP_SORTED;
				if (r < 85) return OP_DELETE;
				if (r < 95) return OP_DUMP;
			end
			default: begin
				if (r < 45) return op_t'($urandom_range(OP_FRONT, OP_SORTED));
				if (r < 80) return OP_DELETE;
				if (r < 96) return OP_DUMP;
			end
		endcase
		return op_t'($urandom_range(OP_SPARE_5, OP_SPARE_7));
	endfunction

	function automatic void report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch: %s", what);
	endfunction

	// Presents one request, waits for it to be taken, then updates the list.
	task automatic issue_request(input op_t op, input data_t v);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_bus.valid     <= 1'b1;
		req_bus.operation <= op;
		req_bus.value     <= v;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		apply_to_list(op, v);
		if (op <= OP_DUMP)
			counted++;
	endtask

	task automatic wait_until_drained();
		req_bus.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Ready toggles in bursts of random stalls and open stretches.
	always @(posedge clk) begin
		if (quiet_tail) begin
			rsp_bus.ready <= 1'b1;
			ready_hold    <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			rsp_bus.ready <= 1'b0;
			ready_hold    <= $urandom_range(1, 16) - 1;
		end else begin
			rsp_bus.ready <= 1'b1;
			ready_hold    <= $urandom_range(1, 32) - 1;
		end
	end

	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d element=%0d length=%0d last=%0b",
					rsp_bus.status, rsp_bus.element, rsp_bus.length, rsp_bus.last));
			end else begin
				want = expected_q.pop_front();
				if (rsp_bus.status !== want.status || rsp_bus.element !== want.element ||
					rsp_bus.length !== want.length || rsp_bus.last !== want.last) begin
					report_mismatch($sformatf(
						"expected st=%0d el=%0d len=%0d last=%0b, got st=%0d el=%0d len=%0d last=%0b",
						want.status, want.element, want.length, want.last,
						rsp_bus.status, rsp_bus.element, rsp_bus.length, rsp_bus.last));
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	initial begin
		directed_row_t row;
		list_result_t  typed_r;
		phase_t        phase;
		int            phase_len;
		op_t           op;
		data_t         v;

		arst_n            <= 1'b0;
		req_bus.valid     <= 1'b0;
		req_bus.operation <= OP_FRONT;
		req_bus.value     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_ROWS; k++) begin
			row = directed_row(k);
			issue_request(row.op, row.value);
			// Rows with a typed answer replace the single predicted result.
			if (row.typed) begin
				typed_r.status  = row.status;
				typed_r.element = '0;
				typed_r.length  = row.length;
				typed_r.last    = 1'b1;
				void'(expected_q.pop_back());
				expected_q.push_back(typed_r);
			end
		end

		// Fill the list to its bound, then push on it while full and dump it.
		while (list_q.size() < DEPTH)
			issue_request(op_t'($urandom_range(OP_FRONT, OP_SORTED)), pick_value());
		issue_request(OP_FRONT, pick_value());
		issue_request(OP_END, pick_value());
		issue_request(OP_SORTED, pick_value());
		issue_request(OP_DUMP, pick_value());
		wait_until_drained();

		while (counted < DIR_ROWS + RANDOM_ITEMS) begin
			phase     = phase_t'($urandom_range(PH_GROW, PH_MIX));
			phase_len = $urandom_range(10, 40);
			if ($urandom_range(0, 3) == 0)
				wait_until_drained();
			for (int n = 0; n < phase_len && counted < DIR_ROWS + RANDOM_ITEMS; n++) begin
				quiet_tail = counted >= DIR_ROWS + RANDOM_ITEMS - TAIL_ITEMS;
				op = pick_operation(phase);
				v  = (op == OP_DELETE) ? pick_delete_value() : pick_value();
				issue_request(op, v);
			end
		end

		req_bus.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
